// File: hw/rtl/pir_pkg.sv
// Shared types and constants for the inscribed-radius block.
// Used by the front, queue and back modules and the top level.
package pir_pkg;

    // Raw field width of every coordinate, normal and offset.
    localparam int unsigned WORD_W = 32;
    // Width of exact sums of squares and of the numerator.
    localparam int unsigned WIDE_W = 64;
    // Width of the radius cap register.
    localparam int unsigned CAP_W = 31;
    // Reset value of the radius cap (10000.0 at 16 fraction bits).
    localparam logic [CAP_W-1:0] CAP_RESET = 31'd655360000;
    // Depth of the queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
    // Register address of the radius cap.
    localparam logic [2:0] ADDR_RADIUS_CAP = 3'd0;

    // One classified face, handed from front to back.
    typedef struct packed {
        logic signed [WIDE_W-1:0] num;     // b - a.p, products truncated toward zero
        logic [WIDE_W-1:0]        sq;      // |a|^2, exact
        logic                     zero;    // normal is all zero
        logic                     last;    // final face of the polytope
    } face_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } queue_ctl_t;

endpackage

// File: hw/rtl/pir_front.sv
// Front end: accepts a face beat, forms |a|^2 and b - a.p with one shared
// multiplier, then pushes the result into the queue.
module pir_front #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [pir_pkg::WORD_W-1:0] point_x,
    input  logic signed [pir_pkg::WORD_W-1:0] point_y,
    input  logic signed [pir_pkg::WORD_W-1:0] point_z,
    input  logic signed [pir_pkg::WORD_W-1:0] normal_x,
    input  logic signed [pir_pkg::WORD_W-1:0] normal_y,
    input  logic signed [pir_pkg::WORD_W-1:0] normal_z,
    input  logic signed [pir_pkg::WORD_W-1:0] face_offset,
    input  logic                              last_face,
    input  logic                              q_full,
    output logic                              q_push,
    output pir_pkg::face_t                    q_data
);
    import pir_pkg::*;

    localparam logic [2:0] STEP_ACC_LAST = 3'd6;
    localparam logic [2:0] STEP_PUSH     = 3'd7;

    logic                     busy_reg, busy_next;
    logic [2:0]               step_reg, step_next;
    logic signed [WORD_W-1:0] nx_reg, ny_reg, nz_reg, px_reg, py_reg, pz_reg;
    logic                     last_reg;
    logic signed [WIDE_W-1:0] prod_reg;
    logic [WIDE_W-1:0]        sq_reg, sq_next;
    logic signed [WIDE_W-1:0] num_reg, num_next;
    logic signed [WORD_W-1:0] op_a, op_b;
    logic signed [WIDE_W-1:0] prod_trunc;
    logic                     accept;

    assign in_stall = busy_reg;
    assign accept   = in_valid && !busy_reg;

    // Operand selection: three squares first, then three dot-product terms.
    always_comb
    begin
        case (step_reg)
            3'd0: begin op_a = nx_reg; op_b = nx_reg; end
            3'd1: begin op_a = ny_reg; op_b = ny_reg; end
            3'd2: begin op_a = nz_reg; op_b = nz_reg; end
            3'd3: begin op_a = nx_reg; op_b = px_reg; end
            3'd4: begin op_a = ny_reg; op_b = py_reg; end
            3'd5: begin op_a = nz_reg; op_b = pz_reg; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    // Product cut to the working fraction, truncated toward zero.
    always_comb
    begin
        if (prod_reg[WIDE_W-1])
            prod_trunc = -((-prod_reg) >>> FRAC_BITS);
        else
            prod_trunc = prod_reg >>> FRAC_BITS;
    end

    // Accumulate the product registered in the previous step.
    always_comb
    begin
        sq_next  = sq_reg;
        num_next = num_reg;
        if (busy_reg)
        begin
            case (step_reg)
                3'd1, 3'd2, 3'd3: sq_next = sq_reg + prod_reg;
                3'd4, 3'd5, STEP_ACC_LAST: num_next = num_reg - prod_trunc;
                default: ;
            endcase
        end
    end

    // Sequencer for the seven compute steps and the push.
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_PUSH)
            begin
                if (!q_full)
                    busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
    end

    assign q_push      = busy_reg && (step_reg == STEP_PUSH) && !q_full;
    assign q_data.num  = num_reg;
    assign q_data.sq   = sq_reg;
    assign q_data.zero = (sq_reg == '0);
    assign q_data.last = last_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Operand capture, shared multiplier and accumulators.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nx_reg   <= normal_x;
            ny_reg   <= normal_y;
            nz_reg   <= normal_z;
            px_reg   <= point_x;
            py_reg   <= point_y;
            pz_reg   <= point_z;
            last_reg <= last_face;
            sq_reg   <= '0;
            num_reg  <= WIDE_W'(face_offset);
        end
        else
        begin
            sq_reg  <= sq_next;
            num_reg <= num_next;
        end
        prod_reg <= op_a * op_b;
    end

endmodule

// File: hw/rtl/pir_queue.sv
// Short queue of classified faces between the front and back ends.
// Depends on pir_pkg for the face type and depth.
module pir_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pir_pkg::face_t      wr_data,
    input  logic                pop,
    output pir_pkg::face_t      rd_data,
    output pir_pkg::queue_ctl_t ctl
);
    import pir_pkg::*;

    face_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign ctl.push  = push;
    assign ctl.pop   = pop;
    assign ctl.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign ctl.empty = (count_reg == '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    // Occupancy update.
    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: ;
        endcase
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: hw/rtl/pir_back.sv
// Back end: integer square root, bit-serial division, running minimum and
// the output register. Depends on pir_pkg for the face type and widths.
module pir_back #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  pir_pkg::face_t                    q_data,
    output logic                              q_pop,
    input  logic [pir_pkg::CAP_W-1:0]         radius_cap,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pir_pkg::WORD_W-1:0] radius,
    output logic                              degenerate_seen
);
    import pir_pkg::*;

    localparam int unsigned SQRT_STEPS = WIDE_W / 2;
    localparam int unsigned SQRT_CNT_W = $clog2(SQRT_STEPS);
    localparam int unsigned DIV_STEPS  = WIDE_W + FRAC_BITS;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int unsigned ROOT_W     = WIDE_W / 2;
    localparam int unsigned REM_W      = ROOT_W + 3;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MIN  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic signed [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    logic [2:0]                state_reg;
    logic [SQRT_CNT_W-1:0]     sqrt_cnt_reg;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;
    logic [WIDE_W-1:0]         src_reg;
    logic [REM_W-1:0]          srem_reg, srem_shift, strial;
    logic [ROOT_W-1:0]         root_reg;
    logic [DIV_STEPS-1:0]      dvd_reg;
    logic [ROOT_W-1:0]         drem_reg;
    logic [ROOT_W:0]           dtrial;
    logic [WORD_W-1:0]         quo_reg;
    logic                      ovf_reg;
    logic                      neg_reg;
    logic                      last_reg;
    logic [WIDE_W-1:0]         mag;
    logic signed [WIDE_W-1:0]  num_reg;
    logic signed [WORD_W-1:0]  min_reg, face_dist, base;
    logic                      min_valid_reg, deg_reg;
    logic                      out_free;

    assign out_free = !out_valid || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign mag      = num_reg[WIDE_W-1] ? WIDE_W'(-num_reg) : WIDE_W'(num_reg);

    // One root bit per step: bring down two radicand bits and trial-subtract.
    assign srem_shift = {srem_reg[REM_W-3:0], src_reg[WIDE_W-1 -: 2]};
    assign strial     = {1'b0, root_reg, 2'b01};

    // One quotient bit per step.
    assign dtrial = {drem_reg, dvd_reg[DIV_STEPS-1]};

    // Saturated signed distance from the finished quotient.
    always_comb
    begin
        if (neg_reg)
            face_dist = (ovf_reg || quo_reg[WORD_W-1]) ? SAT_MIN : -$signed(quo_reg);
        else
            face_dist = (ovf_reg || quo_reg[WORD_W-1]) ? SAT_MAX : $signed(quo_reg);
        base = min_valid_reg ? min_reg : $signed({1'b0, radius_cap});
    end

    // Sequencer and control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_valid_reg <= 1'b0;
            deg_reg       <= 1'b0;
            out_valid     <= 1'b0;
        end
        else
        begin
            // The output register loads in the emit state and empties when taken.
            if (state_reg == ST_EMIT && out_free)
                out_valid <= 1'b1;
            else if (out_valid && !out_stall)
                out_valid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (q_data.zero)
                        begin
                            deg_reg   <= 1'b1;
                            state_reg <= q_data.last ? ST_EMIT : ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT:
                begin
                    if (sqrt_cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                        state_reg <= ST_MIN;
                end
                ST_MIN:
                begin
                    min_valid_reg <= 1'b1;
                    state_reg     <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        min_valid_reg <= 1'b0;
                        deg_reg       <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath of the root, the divider and the minimum.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                src_reg      <= q_data.sq;
                num_reg      <= q_data.num;
                last_reg     <= q_data.last;
                srem_reg     <= '0;
                root_reg     <= '0;
                sqrt_cnt_reg <= '0;
            end
            ST_SQRT:
            begin
                src_reg      <= src_reg << 2;
                sqrt_cnt_reg <= sqrt_cnt_reg + 1'b1;
                if (srem_shift >= strial)
                begin
                    srem_reg <= srem_shift - strial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                // Load the dividend for the following division.
                dvd_reg     <= {mag, {FRAC_BITS{1'b0}}};
                neg_reg     <= num_reg[WIDE_W-1];
                drem_reg    <= '0;
                quo_reg     <= '0;
                ovf_reg     <= 1'b0;
                div_cnt_reg <= '0;
            end
            ST_DIV:
            begin
                dvd_reg     <= dvd_reg << 1;
                div_cnt_reg <= div_cnt_reg + 1'b1;
                ovf_reg     <= ovf_reg | quo_reg[WORD_W-1];
                if (dtrial >= {1'b0, root_reg})
                begin
                    drem_reg <= ROOT_W'(dtrial - {1'b0, root_reg});
                    quo_reg  <= {quo_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dtrial[ROOT_W-1:0];
                    quo_reg  <= {quo_reg[WORD_W-2:0], 1'b0};
                end
            end
            ST_MIN:
            begin
                min_reg <= (face_dist < base) ? face_dist : base;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    radius          <= min_valid_reg ? min_reg : $signed({1'b0, radius_cap});
                    degenerate_seen <= deg_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: hw/rtl/polytope_inscribed_radius.sv
// Inscribed radius of a convex polytope at a query point: each face beat
// gives (b - a.p)/|a| in signed fixed point, the minimum is emitted on the
// last face. A face with a nonzero normal holds the back end through the
// pop, the one-bit-per-cycle square root and divider, and the minimum
// step; the last face also loads the output register. The front end
// computes the next face's sums meanwhile, and a two-entry queue lets it
// run ahead. A zero-normal face sets degenerate_seen. The radius cap sits
// at APB byte address 0.
module polytope_inscribed_radius #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Face input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [pir_pkg::WORD_W-1:0] point_x,
    input  logic signed [pir_pkg::WORD_W-1:0] point_y,
    input  logic signed [pir_pkg::WORD_W-1:0] point_z,
    input  logic signed [pir_pkg::WORD_W-1:0] normal_x,
    input  logic signed [pir_pkg::WORD_W-1:0] normal_y,
    input  logic signed [pir_pkg::WORD_W-1:0] normal_z,
    input  logic signed [pir_pkg::WORD_W-1:0] face_offset,
    input  logic                              last_face,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pir_pkg::WORD_W-1:0] radius,
    output logic                              degenerate_seen
);
    import pir_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    face_t            push_data, pop_data;
    queue_ctl_t       qctl;
    logic             q_push, q_pop;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RADIUS_CAP) ? {1'b0, cap_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_RADIUS_CAP)
            cap_reg <= pwdata[CAP_W-1:0];
    end

    // Front end.
    pir_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .face_offset (face_offset),
        .last_face   (last_face),
        .q_full      (qctl.full),
        .q_push      (q_push),
        .q_data      (push_data)
    );

    // Queue between the two ends.
    pir_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_data),
        .pop     (q_pop),
        .rd_data (pop_data),
        .ctl     (qctl)
    );

    // Back end.
    pir_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (qctl.empty),
        .q_data          (pop_data),
        .q_pop           (q_pop),
        .radius_cap      (cap_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .radius          (radius),
        .degenerate_seen (degenerate_seen)
    );

`ifndef SYNTHESIS
    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        qctl.push |-> !qctl.full)
        else $error("face pushed into a full queue");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        qctl.pop |-> !qctl.empty)
        else $error("face popped from an empty queue");

    // A stalled result beat stays valid and unchanged until it is taken.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(radius) && $stable(degenerate_seen))
        else $error("stalled result beat changed");
`endif

endmodule
